/* src/srb_pkg.sv */
// Shared types and constants of the sequence reorder buffer.
// No dependencies; imported by sequence_reorder_buffer_top.
package srb_pkg;

  localparam int unsigned SeqW = 32;
  localparam int unsigned LenW = 12;
  localparam int unsigned HdlW = 16;
  localparam int unsigned TmoW = 16;
  localparam int unsigned StW  = 3;
  localparam int unsigned CfgW = 16;

  typedef enum logic [1:0] {
    CMD_ARRIVE = 2'd0,
    CMD_POLL   = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_SEND  = 2'd0,
    MODE_LINK  = 2'd1,
    MODE_RECV  = 2'd2,
    MODE_SPARE = 2'd3
  } mode_e;

  typedef enum logic [StW-1:0] {
    ST_PASSED    = 3'd0,
    ST_DELIVERED = 3'd1,
    ST_BUFFERED  = 3'd2,
    ST_DUPLICATE = 3'd3,
    ST_NONE      = 3'd4,
    ST_NUMBERED  = 3'd5
  } status_e;

  localparam logic REG_ROLE_MODE = 1'b0;
  localparam logic REG_TIMEOUT   = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_EXEC,
    S_RD,
    S_CMP,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [LenW-1:0] len;
    logic [HdlW-1:0] hdl;
    logic [SeqW-1:0] stamp;
  } slot_t;

endpackage

/* src/sequence_reorder_buffer_top.sv */
// Sequence reorder buffer: numbering, pass-through and receive-side reordering.
// Depends on srb_pkg; holds the slot memory and the scan sequencer.
//
// Usage:
//   Items enter on in_valid_i/in_ready_o (command, sequence, length, handle,
//   space limit); each gives exactly one result on out_valid_o/out_ready_i.
//   Registers are written over cfg_we_i/cfg_idx_i/cfg_data_i while idle;
//   the user must keep to this, as the block itself does not enforce it.
//   An item is taken only while the sequencer is idle. For a WINDOW that is
//   not a power of two, a receive-side arrival gets its slot index from a
//   reciprocal multiply, a fixup and a subtract before it executes.
//   A poll walks the window through the single slot memory read port and
//   one age/length compare unit, each slot visited passing through a read
//   state and a compare state; the in-order entry is tried first, then a rescan.
//   The result sits in an output register; a stalled receiver holds it and
//   the next item finishes its work and waits in the sequencer behind it.
//   Reset clears counters, the clock and all slot-present bits at once;
//   no clearing pass is needed.
module sequence_reorder_buffer_top
  import srb_pkg::*;
#(
  parameter int unsigned WINDOW       = 64,
  parameter int unsigned HEADER_BYTES = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [0:0]      cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      command_i,
  input  logic [SeqW-1:0] seq_number_i,
  input  logic [LenW-1:0] pkt_len_i,
  input  logic [HdlW-1:0] buffer_handle_i,
  input  logic [LenW-1:0] space_limit_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [StW-1:0]  status_o,
  output logic [SeqW-1:0] out_seq_o,
  output logic [LenW-1:0] out_len_o,
  output logic [HdlW-1:0] out_handle_o
);

  localparam int unsigned AW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam bit          POW2 = ((WINDOW & (WINDOW - 1)) == 0);
  localparam logic [AW-1:0]   LastIdx = AW'(WINDOW - 1);
  localparam logic [AW-1:0]   WinLo   = AW'(WINDOW);
  localparam logic [LenW-1:0] HdrLen  = LenW'(HEADER_BYTES);
  // reciprocal for sequence / WINDOW, used only when WINDOW is not a power of two
  localparam logic [2*SeqW-1:0] Magic64 =
    ((64'd1 << SeqW) * ((64'd1 << AW) - 64'(WINDOW))) / 64'(WINDOW) + 64'd1;
  localparam logic [SeqW-1:0] Magic = Magic64[SeqW-1:0];

  state_e state_q, state_d;

  logic [1:0]      mode_q;
  logic [TmoW-1:0] tmo_q;
  logic [SeqW-1:0] send_q, send_d;
  logic [SeqW-1:0] exp_q, exp_d;
  logic [AW-1:0]   exp_idx_q, exp_idx_d;
  logic [SeqW-1:0] hi_q, hi_d;
  logic [SeqW-1:0] now_q, now_d;
  logic [WINDOW-1:0] present_q, present_d;

  logic [1:0]      cmd_q;
  logic [SeqW-1:0] seq_q, seq_d;
  logic [LenW-1:0] len_q;
  logic [HdlW-1:0] hdl_q;
  logic [LenW-1:0] space_q;

  logic [AW-1:0]   rem_q, rem_d;
  logic [SeqW-1:0] quo_q, quo_d;
  logic [5:0]      cnt_q, cnt_d;
  logic [AW-1:0]   k_q, k_d, lim_q, lim_d, addr_q, addr_d;
  logic            pass0_q, pass0_d, pres_q;

  logic [StW-1:0]  rst_q, rst_d;
  logic [SeqW-1:0] rseq_q, rseq_d;
  logic [LenW-1:0] rlen_q, rlen_d;
  logic [HdlW-1:0] rhdl_q, rhdl_d;

  logic            out_valid_q;
  logic [StW-1:0]  ost_q;
  logic [SeqW-1:0] oseq_q;
  logic [LenW-1:0] olen_q;
  logic [HdlW-1:0] ohdl_q;

  slot_t           mem_q [WINDOW];
  slot_t           rdata_q, wdata;
  logic            mem_we, rd_en;

  logic            arr_rx, hit, out_free;
  logic [AW-1:0]   idx;
  logic [2*SeqW-1:0] prod;
  logic [AW-1:0]   mul_lo;
  logic [SeqW-1:0] diff, age;
  logic [LenW:0]   nl;

  assign in_ready_o = (state_q == S_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;
  assign arr_rx     = (cmd_q == CMD_ARRIVE) && (mode_q == MODE_RECV) && (len_q >= HdrLen);
  assign idx        = POW2 ? seq_q[AW-1:0] : rem_q;
  assign prod       = 64'(seq_q) * 64'(Magic);
  assign mul_lo     = quo_q[AW-1:0] * WinLo;
  assign diff       = hi_q - exp_q;
  assign age        = now_q - rdata_q.stamp;
  assign nl         = {1'b0, len_q} + {1'b0, HdrLen};
  assign hit        = pres_q && (rdata_q.len <= space_q) &&
                      (pass0_q || (age > {{(SeqW-TmoW){1'b0}}, tmo_q}));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_MOD;
      S_MOD:  if (POW2 || !arr_rx || cnt_q == '0) state_d = S_EXEC;
      S_EXEC: begin
        if (cmd_q == CMD_POLL && mode_q == MODE_RECV && exp_q <= hi_q) state_d = S_RD;
        else state_d = S_DONE;
      end
      S_RD:   state_d = S_CMP;
      S_CMP: begin
        if (hit || (!pass0_q && k_q == lim_q)) state_d = S_DONE;
        else state_d = S_RD;
      end
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    send_d    = send_q;
    exp_d     = exp_q;
    exp_idx_d = exp_idx_q;
    hi_d      = hi_q;
    now_d     = now_q;
    present_d = present_q;
    seq_d     = seq_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    cnt_d     = cnt_q;
    k_d       = k_q;
    lim_d     = lim_q;
    addr_d    = addr_q;
    pass0_d   = pass0_q;
    rst_d     = rst_q;
    rseq_d    = rseq_q;
    rlen_d    = rlen_q;
    rhdl_d    = rhdl_q;
    mem_we    = 1'b0;
    rd_en     = 1'b0;
    wdata.len   = len_q - HdrLen;
    wdata.hdl   = hdl_q;
    wdata.stamp = now_q;
    case (state_q)
      S_IDLE: begin
        seq_d = seq_number_i;
        rem_d = '0;
        cnt_d = 6'd3;
      end
      S_MOD: begin
        // quotient by reciprocal multiply and fixup, then subtract for the remainder
        if (!POW2 && arr_rx && cnt_q != '0) begin
          if (cnt_q == 6'd3) quo_d = prod[2*SeqW-1:SeqW];
          else if (cnt_q == 6'd2) quo_d = (quo_q + ((seq_q - quo_q) >> 1)) >> (AW - 1);
          else rem_d = seq_q[AW-1:0] - mul_lo;
          cnt_d = cnt_q - 6'd1;
        end
      end
      S_EXEC: begin
        rst_d  = ST_NONE;
        rseq_d = '0;
        rlen_d = '0;
        rhdl_d = '0;
        case (cmd_q)
          CMD_ARRIVE: begin
            if (mode_q == MODE_SEND) begin
              rst_d  = ST_NUMBERED;
              rseq_d = send_q;
              rlen_d = nl[LenW] ? '1 : nl[LenW-1:0];
              rhdl_d = hdl_q;
              send_d = send_q + 1'b1;
            end else if (!arr_rx) begin
              rst_d  = ST_PASSED;
              rlen_d = len_q;
              rhdl_d = hdl_q;
            end else if (present_q[idx]) begin
              rst_d = ST_DUPLICATE;
            end else begin
              mem_we = 1'b1;
              if (seq_q > hi_q) hi_d = seq_q;
              if (seq_q == exp_q) begin
                rst_d     = ST_DELIVERED;
                rseq_d    = seq_q;
                rlen_d    = wdata.len;
                rhdl_d    = hdl_q;
                exp_d     = exp_q + 1'b1;
                exp_idx_d = (exp_idx_q == LastIdx) ? '0 : exp_idx_q + 1'b1;
              end else begin
                rst_d          = ST_BUFFERED;
                present_d[idx] = 1'b1;
              end
            end
          end
          CMD_POLL: begin
            k_d     = '0;
            pass0_d = 1'b1;
            addr_d  = exp_idx_q;
            lim_d   = (diff >= SeqW'(WINDOW - 1)) ? LastIdx : diff[AW-1:0];
          end
          CMD_TICK: now_d = now_q + 1'b1;
          default: ;
        endcase
      end
      S_RD: rd_en = 1'b1;
      S_CMP: begin
        if (hit) begin
          rst_d  = ST_DELIVERED;
          rseq_d = exp_q + {{(SeqW-AW){1'b0}}, k_q};
          rlen_d = rdata_q.len;
          rhdl_d = rdata_q.hdl;
          present_d[addr_q] = 1'b0;
          if (k_q == '0) begin
            exp_d     = exp_q + 1'b1;
            exp_idx_d = (exp_idx_q == LastIdx) ? '0 : exp_idx_q + 1'b1;
          end
        end else if (pass0_q) begin
          // in-order entry missed: rescan from the start on age
          pass0_d = 1'b0;
          k_d     = '0;
          addr_d  = exp_idx_q;
        end else if (k_q != lim_q) begin
          k_d    = k_q + 1'b1;
          addr_d = (addr_q == LastIdx) ? '0 : addr_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_RECV;
      tmo_q       <= TmoW'(100);
      send_q      <= '0;
      exp_q       <= '0;
      exp_idx_q   <= '0;
      hi_q        <= '0;
      now_q       <= '0;
      present_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      send_q    <= send_d;
      exp_q     <= exp_d;
      exp_idx_q <= exp_idx_d;
      hi_q      <= hi_d;
      now_q     <= now_d;
      present_q <= present_d;
      if (cfg_we_i) begin
        if (cfg_idx_i[0] == REG_ROLE_MODE) mode_q <= cfg_data_i[1:0];
        if (cfg_idx_i[0] == REG_TIMEOUT)   tmo_q  <= cfg_data_i;
      end
      if (state_q == S_DONE && out_free) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE) begin
      cmd_q   <= command_i;
      len_q   <= pkt_len_i;
      hdl_q   <= buffer_handle_i;
      space_q <= space_limit_i;
    end
    seq_q   <= seq_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    cnt_q   <= cnt_d;
    k_q     <= k_d;
    lim_q   <= lim_d;
    addr_q  <= addr_d;
    pass0_q <= pass0_d;
    rst_q   <= rst_d;
    rseq_q  <= rseq_d;
    rlen_q  <= rlen_d;
    rhdl_q  <= rhdl_d;
    if (state_q == S_RD) pres_q <= present_q[addr_q];
    if (state_q == S_DONE && out_free) begin
      ost_q  <= rst_q;
      oseq_q <= rseq_q;
      olen_q <= rlen_q;
      ohdl_q <= rhdl_q;
    end
  end

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[idx] <= wdata;
    if (rd_en) rdata_q <= mem_q[addr_q];
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = ost_q;
  assign out_seq_o    = oseq_q;
  assign out_len_o    = olen_q;
  assign out_handle_o = ohdl_q;

`ifndef SYNTHESIS
  a_exp_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exp_q != $past(exp_q)) |-> (exp_q == $past(exp_q) + 1'b1))
    else $error("expected sequence jumped");
  a_exp_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exp_idx_q <= LastIdx)
    else $error("expected index out of window");
  a_cmp_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD) |=> (state_q == S_CMP))
    else $error("compare did not follow read");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_MOD))
    else $error("accepted item not started");
`endif

endmodule
